// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants and types for the buddy bitmap allocator
// ----------------------------------------------------------------------------
package bba_pkg;
  localparam int PAGE_BYTES     = 4096;
  localparam int TREE_LAYERS    = 8;
  localparam int MAX_PAGES      = 64;
  localparam int RESERVED_LAYER = 5;
  localparam int NODES          = 1 << TREE_LAYERS;
  localparam int PAGE_W         = $clog2(MAX_PAGES);
  localparam int NODE_W         = TREE_LAYERS;
  localparam int MEM_AW         = PAGE_W + NODE_W;
  localparam int OFF_W          = $clog2(PAGE_BYTES);
  localparam int LAYER_W        = $clog2(TREE_LAYERS);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_MEM   = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RDA, S_A_RDB, S_A_CHK, S_A_MARK,
    S_F_RD, S_F_CHK, S_F_BUD, S_F_BCHK, S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic              wdata;
  } mem_req_t;

  // heap index of node idx in layer
  function automatic logic [NODE_W-1:0] node_ix(input logic [LAYER_W-1:0] layer,
                                                 input logic [NODE_W-1:0] idx);
    node_ix = NODE_W'((32'd1 << layer) - 32'd1 + 32'(idx));
  endfunction
endpackage
`default_nettype wire

// ===== sv/bba_map_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_map_ram
// used-bit memory, one read/write port, registered read data
// ----------------------------------------------------------------------------
module bba_map_ram
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic          rdata
);
  logic mem [(1 << MEM_AW)];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

// ===== sv/bba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer: clearing pass, alloc pair scan and marking, free climb
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [47:0] base_address,
  input  wire logic [6:0]  page_count,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [12:0] request_bytes,
  input  wire logic [47:0] free_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      block_address,
  output logic [1:0]       status,
  output mem_req_t         req,
  input  wire logic        rdata
);
  state_t state, state_next;
  logic [MEM_AW:0]      clr_cnt;
  logic [PAGE_W:0]      page;
  logic [LAYER_W-1:0]   layer, best;
  logic [NODE_W-1:0]    j;
  logic                 bit_a;
  logic [47:0]          res_addr;
  logic [1:0]           res_st;
  logic [6:0]           pages_used;
  logic [47:0]          d;
  logic [OFF_W-1:0]     off;

  assign pages_used = (page_count > 7'(MAX_PAGES)) ? 7'(MAX_PAGES) : page_count;
  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_DONE);
  assign block_address = res_addr;
  assign status        = res_st;

  function automatic logic [LAYER_W-1:0] pick_layer(input logic [12:0] r);
    logic [12:0] need;
    pick_layer = LAYER_W'(1);
    need = (r == 13'd0) ? 13'd1 : r;
    for (int l = 1; l < TREE_LAYERS; l++) begin
      if (13'(PAGE_BYTES >> l) >= need) pick_layer = LAYER_W'(l);
    end
  endfunction

  function automatic logic [MEM_AW-1:0] maddr(input logic [PAGE_W:0] p,
                                               input logic [LAYER_W-1:0] l,
                                               input logic [NODE_W-1:0] i);
    maddr = {p[PAGE_W-1:0], node_ix(l, i)};
  endfunction

  // reset content: leftmost node of layers 0..reserved set
  function automatic logic rst_bit(input logic [NODE_W-1:0] n);
    rst_bit = 1'b0;
    for (int l = 0; l <= RESERVED_LAYER && l < TREE_LAYERS; l++) begin
      if (n == NODE_W'((1 << l) - 1)) rst_bit = 1'b1;
    end
  endfunction

  logic last_pair;
  assign last_pair = (32'(j) + 32'd2 >= (32'd1 << layer));

  always_comb begin
    state_next = state;
    req = '0;
    case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.addr  = clr_cnt[MEM_AW-1:0];
        req.wdata = rst_bit(clr_cnt[NODE_W-1:0]);
        if (clr_cnt == (MEM_AW+1)'((1 << MEM_AW) - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) state_next = (kind == KIND_ALLOC) ? S_A_RDA : S_F_RD;
      S_A_RDA: begin
        if (res_st == ST_TOO_BIG) state_next = S_DONE;
        else if (page >= (PAGE_W+1)'(pages_used)) state_next = S_DONE;
        else begin
          req.addr = maddr(page, layer, j);
          state_next = S_A_RDB;
        end
      end
      S_A_RDB: begin
        req.addr = maddr(page, layer, j | NODE_W'(1));
        state_next = S_A_CHK;
      end
      S_A_CHK: state_next = (bit_a ^ rdata) ? S_A_MARK : S_A_RDA;
      S_A_MARK: begin
        req.we = 1'b1; req.wdata = 1'b1;
        req.addr = maddr(page, layer, j);
        if (layer == best) state_next = S_DONE;
      end
      S_F_RD: begin
        if (res_st != ST_OK) state_next = S_DONE;
        else begin
          req.addr = maddr(page, layer, j);
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (rdata) begin
          req.we = 1'b1; req.addr = maddr(page, layer, j);
          state_next = S_F_BUD;
        end else state_next = S_F_RD;
      end
      S_F_BUD: begin
        req.addr = maddr(page, layer, j ^ NODE_W'(1));
        state_next = S_F_BCHK;
      end
      S_F_BCHK: begin
        if (rdata) state_next = S_DONE;
        else begin
          req.we = 1'b1;
          req.addr = maddr(page, layer - LAYER_W'(1), j >> 1);
          state_next = (layer == LAYER_W'(1)) ? S_DONE : S_F_BUD;
        end
      end
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign d   = free_address - base_address;
  assign off = d[OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
    case (state)
      S_IDLE: begin
        page     <= '0;
        j        <= '0;
        res_addr <= '0;
        res_st   <= ST_OK;
        if (kind == KIND_ALLOC) begin
          best  <= pick_layer(request_bytes);
          layer <= pick_layer(request_bytes);
          if (request_bytes > 13'(PAGE_BYTES / 2)) res_st <= ST_TOO_BIG;
          else res_st <= ST_NO_MEM;
        end else begin
          layer <= LAYER_W'(TREE_LAYERS - 1);
          j     <= NODE_W'(off >> (OFF_W - TREE_LAYERS + 1));
          page  <= (PAGE_W+1)'(d >> OFF_W);
          // offset must at least be aligned to the finest block
          if (free_address < base_address ||
              (d >> OFF_W) >= 48'(pages_used) ||
              off[OFF_W-TREE_LAYERS:0] != '0) res_st <= ST_NOT_ALLOC;
        end
      end
      S_A_RDA: if (res_st == ST_NO_MEM && page >= (PAGE_W+1)'(pages_used)) res_st <= ST_NO_MEM;
      S_A_RDB: bit_a <= rdata;
      S_A_CHK: begin
        if (bit_a ^ rdata) begin
          j <= j + NODE_W'(bit_a);
        end else if (!last_pair) begin
          j <= j + NODE_W'(2);
        end else if (layer != LAYER_W'(1)) begin
          layer <= layer - LAYER_W'(1); j <= '0;
        end else begin
          layer <= best; j <= '0; page <= page + 1'b1;
        end
      end
      S_A_MARK: begin
        if (layer == best) begin
          res_st   <= ST_OK;
          res_addr <= base_address + (48'(page[PAGE_W-1:0]) << OFF_W)
                      + (48'(j) << (OFF_W - best));
        end else begin
          layer <= layer + LAYER_W'(1);
          j     <= j << 1;
        end
      end
      S_F_RD: ;
      S_F_CHK: begin
        if (!rdata) begin
          // try the next coarser layer if the offset stays aligned
          if (layer == LAYER_W'(1) || j[0]) res_st <= ST_NOT_ALLOC;
          else begin
            layer <= layer - LAYER_W'(1);
            j     <= j >> 1;
          end
        end
      end
      S_F_BCHK: if (!rdata) begin
        layer <= layer - LAYER_W'(1);
        j     <= j >> 1;
      end
      default: ;
    endcase
  end

  property p_out_hold;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_mark_layer: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_MARK) |-> (layer <= best)) else $error("mark past wanted layer");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_st != ST_OK) |-> (res_addr == 48'd0)) else $error("addr on failure");
endmodule
`default_nettype wire

// ===== sv/buddy_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_bitmap_allocator_core
// buddy allocator over pages of used-bit trees, one request per handshake
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass writes every word of
// the used-bit memory; no request is taken until it ends. An allocate reads
// sibling pairs from the single-port memory, then marks one node in each
// layer from the free one found down to the wanted layer; a free searches
// the layers for the used node, then clears ancestors while the buddy is
// free. The result is held until it is taken.
module buddy_bitmap_allocator_core
  import bba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // request_bytes[12:0], free_address[60:13]
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // block_address[47:0], status[49:48]
);
  localparam logic [3:0] A_BASE  = 4'd0;
  localparam logic [3:0] A_PAGES = 4'd8;
  logic [47:0] base_address;
  logic [6:0]  page_count;
  mem_req_t    req;
  logic        rdata;
  logic [47:0] block_address;
  logic [1:0]  status;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      page_count   <= 7'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr == A_BASE) base_address <= pwdata[47:0];
      else if (paddr == A_PAGES) page_count <= pwdata[6:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == A_BASE) prdata = {16'd0, base_address};
    else if (paddr == A_PAGES) prdata = {57'd0, page_count};
  end

  bba_ctrl u_ctrl (
    .clk, .rst, .base_address, .page_count,
    .in_valid(s_tvalid), .in_ready(s_tready), .kind(s_tuser),
    .request_bytes(s_tdata[12:0]), .free_address(s_tdata[60:13]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .block_address, .status, .req, .rdata
  );
  bba_map_ram u_ram (.clk, .req, .rdata);

  assign m_tdata = {6'd0, status, block_address};
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives allocate and free requests into the buddy allocator and compares
// every returned address and status with a bit-level tree predictor
// ----------------------------------------------------------------------------

class alloc_scoreboard;
  bit              used_bit[bba_pkg::MAX_PAGES][bba_pkg::NODES];
  logic [47:0]     cfg_base;
  logic [6:0]      pages;
  logic [49:0]     pending_q[$];
  int              fail_cnt;
  logic [47:0]     held_q[$];

  function new();
    for (int p = 0; p < bba_pkg::MAX_PAGES; p++) begin
      for (int n = 0; n < bba_pkg::NODES; n++) used_bit[p][n] = 0;
      for (int l = 0; l <= bba_pkg::RESERVED_LAYER && l < bba_pkg::TREE_LAYERS; l++)
        used_bit[p][(1 << l) - 1] = 1;
    end
    cfg_base = '0;
    pages = 7'd1;
    fail_cnt = 0;
  endfunction

  function int heap_ix(int layer, longint idx);
    return int'((longint'(1 << layer) - 1 + idx) & (bba_pkg::NODES - 1));
  endfunction

  function int active_pages();
    return (pages > bba_pkg::MAX_PAGES) ? bba_pkg::MAX_PAGES : int'(pages);
  endfunction

  function logic [1:0] try_alloc(longint req, output logic [47:0] addr);
    int best, l;
    longint need, j;
    bit a, b;
    addr = '0;
    need = (req == 0) ? 1 : req;
    if (req > bba_pkg::PAGE_BYTES / 2) return bba_pkg::ST_TOO_BIG;
    best = 1;
    for (int ly = bba_pkg::TREE_LAYERS - 1; ly >= 1; ly--)
      if ((bba_pkg::PAGE_BYTES >> ly) >= need) begin
        best = ly;
        break;
      end
    for (int p = 0; p < active_pages(); p++)
      for (int ly = best; ly >= 1; ly--)
        for (longint k = 0; k < (longint'(1) << ly); k += 2) begin
          a = used_bit[p][heap_ix(ly, k)];
          b = used_bit[p][heap_ix(ly, k + 1)];
          if (a == b) continue;
          j = k + a;
          l = ly;
          used_bit[p][heap_ix(l, j)] = 1;
          while (l != best) begin
            l++;
            j = j << 1;
            used_bit[p][heap_ix(l, j)] = 1;
          end
          addr = cfg_base + 48'(p) * bba_pkg::PAGE_BYTES
                 + 48'(j * (bba_pkg::PAGE_BYTES >> best));
          return bba_pkg::ST_OK;
        end
    return bba_pkg::ST_NO_MEM;
  endfunction

  function logic [1:0] try_free(logic [47:0] va);
    logic [47:0] d;
    longint pg, o, j, bs;
    if (va < cfg_base) return bba_pkg::ST_NOT_ALLOC;
    d = va - cfg_base;
    pg = d / bba_pkg::PAGE_BYTES;
    if (pg >= active_pages()) return bba_pkg::ST_NOT_ALLOC;
    o = d % bba_pkg::PAGE_BYTES;
    for (int ly = bba_pkg::TREE_LAYERS - 1; ly >= 1; ly--) begin
      bs = bba_pkg::PAGE_BYTES >> ly;
      if (bs == 0) continue;
      if (o % bs != 0) break;
      j = o / bs;
      if (!used_bit[pg][heap_ix(ly, j)]) continue;
      used_bit[pg][heap_ix(ly, j)] = 0;
      forever begin
        if (used_bit[pg][heap_ix(ly, j ^ 1)]) return bba_pkg::ST_OK;
        j = j >> 1;
        ly--;
        used_bit[pg][heap_ix(ly, j)] = 0;
        if (ly == 0) return bba_pkg::ST_OK;
      end
    end
    return bba_pkg::ST_NOT_ALLOC;
  endfunction

  function void note_request(logic kind, logic [12:0] req, logic [47:0] va);
    logic [47:0] addr;
    logic [1:0]  st;
    addr = '0;
    if (kind == bba_pkg::KIND_ALLOC) st = try_alloc(longint'(req), addr);
    else st = try_free(va);
    if (st != bba_pkg::ST_OK) addr = '0;
    if (kind == bba_pkg::KIND_ALLOC && st == bba_pkg::ST_OK) held_q.push_back(addr);
    pending_q.push_back({st, addr});
  endfunction

  function void check_result(logic [55:0] data);
    logic [49:0] exp;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat %h", data);
      fail_cnt++;
      return;
    end
    exp = pending_q.pop_front();
    if (data[47:0] !== exp[47:0]) begin
      $error("block_address expected %h actual %h", exp[47:0], data[47:0]);
      fail_cnt++;
    end
    if (data[49:48] !== exp[49:48]) begin
      $error("status expected %0d actual %0d", exp[49:48], data[49:48]);
      fail_cnt++;
    end
  endfunction
endclass

module tb;
  import bba_pkg::*;

  localparam int KIND_FREE_V = 1;
  localparam logic [3:0] REG_BASE  = 4'd0;
  localparam logic [3:0] REG_PAGES = 4'd8;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;

  alloc_scoreboard sb = new();
  longint cycles = 0;
  bit     rx_stall_long = 0;

  buddy_bitmap_allocator_core i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 60_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check beats, random back-pressure
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ($urandom_range(0, 3) == 0) m_tready <= 1'b0;
      else if (rx_stall_long && $urandom_range(0, 20) != 0) m_tready <= 1'b0;
      else m_tready <= 1'b1;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] a, logic [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == REG_BASE) sb.cfg_base = v[47:0];
    else sb.pages = v[6:0];
    @(posedge clk);
  endtask

  task automatic send_req(logic kind, logic [12:0] req, logic [47:0] va);
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {3'b0, va, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(kind, req, va);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [47:0] va;
    int pick;
    for (int i = 0; i < n; i++) begin
      idle_gap();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // mostly small sizes, some at the top of the range
        if ($urandom_range(0, 4) == 0) send_req(KIND_ALLOC, 13'($urandom_range(0, 8191)), '0);
        else send_req(KIND_ALLOC, 13'($urandom_range(0, 2048)), '0);
      end else if (pick < 85 && sb.held_q.size() != 0) begin
        int k;
        k = $urandom_range(0, sb.held_q.size() - 1);
        va = sb.held_q[k];
        sb.held_q.delete(k);
        send_req(1'(KIND_FREE_V), 13'($urandom), va);
      end else begin
        va = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
          va = sb.cfg_base + 48'($urandom_range(0, 70 * PAGE_BYTES)) & 48'hFFFF_FFFF_FFF0;
        send_req(1'(KIND_FREE_V), 13'($urandom), va);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, both operations, each error case
    send_req(KIND_ALLOC, 13'd0, '0);
    send_req(KIND_ALLOC, 13'd2048, '0);
    send_req(KIND_ALLOC, 13'd2049, '0);
    send_req(KIND_ALLOC, 13'h1FFF, '0);
    send_req(KIND_ALLOC, 13'd4096, '0);
    send_req(KIND_ALLOC, 13'd16, '0);
    send_req(KIND_ALLOC, 13'd17, '0);
    send_req(KIND_ALLOC, 13'd1024, '0);
    send_req(KIND_ALLOC, 13'd1024, '0);
    send_req(1'(KIND_FREE_V), 13'h1FFF, 48'hFFFF_FFFF_FFFF);
    send_req(1'(KIND_FREE_V), '0, 48'd4096);
    send_req(1'(KIND_FREE_V), '0, 48'd3);
    send_req(1'(KIND_FREE_V), '0, 48'd0);
    send_req(1'(KIND_FREE_V), '0, 48'd2048);
    send_req(1'(KIND_FREE_V), '0, 48'd2048);
    drain();
    sb.held_q.delete();

    write_reg(REG_BASE, 64'hFFFF_FFFF_F000);
    write_reg(REG_PAGES, 64'd2);
    send_req(KIND_ALLOC, 13'd2048, '0);
    send_req(KIND_ALLOC, 13'd2048, '0);
    send_req(KIND_ALLOC, 13'd2048, '0);
    send_req(1'(KIND_FREE_V), '0, 48'h0);
    send_req(1'(KIND_FREE_V), '0, 48'hFFFF_FFFF_E000);
    drain();
    write_reg(REG_PAGES, 64'd0);
    send_req(KIND_ALLOC, 13'd1, '0);
    drain();
    sb.held_q.delete();

    write_reg(REG_BASE, 64'h0000_1234_5000);
    write_reg(REG_PAGES, 64'd3);
    random_phase(250);
    drain();
    sb.held_q.delete();
    write_reg(REG_PAGES, 64'd64);
    write_reg(REG_BASE, 64'h0);
    rx_stall_long = 1;
    random_phase(150);
    rx_stall_long = 0;
    drain();
    sb.held_q.delete();
    write_reg(REG_PAGES, 64'd127);
    write_reg(REG_BASE, {16'h0, 4'hA, 44'h0});
    random_phase(200);
    drain();
    sb.held_q.delete();
    write_reg(REG_PAGES, 64'd1);
    write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF);
    random_phase(180);
    drain();

    if (sb.fail_cnt == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bba_map_ram.sv
sv/bba_ctrl.sv
sv/buddy_bitmap_allocator_core.sv
bench/tb.sv
